>>> rtl/core/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// No dependencies; the core, the checker and the testbench refer to this package.
`timescale 1ns / 1ps

package ile_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_MIN    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_POS   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_INSERT = 2'd1,
    S_DELETE = 2'd2,
    S_MIN    = 2'd3
  } state_t;

endpackage

>>> rtl/core/ile_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/indexed_list_engine_core.sv
// Top level of the indexed list engine: sequencer, list count and result registers.
// Depends on ile_pkg and ile_ram.
//
// An ordered list of signed 32-bit values held in one RAM of CAPACITY entries.
// A request is taken when start is high and busy is low; its result appears on
// status, result_value and entry_count for exactly one cycle with done high, in the
// cycle after the request finishes, and the receiver cannot stall it. Append and
// every rejected request finish in the cycle they are taken, so done follows on
// the next cycle. Insert and delete move one entry per cycle through the single
// RAM port pair, except that an insert at a position equal to the count moves
// nothing; a minimum scans one entry per cycle through one signed comparator.
// The result registers hold their values until the next request is taken.
`timescale 1ns / 1ps

module indexed_list_engine_core #(
  parameter int CAPACITY = ile_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  ile_pkg::action_t                    action,
  input  logic [$clog2(CAPACITY+1)-1:0]       position,
  input  logic signed [ile_pkg::DATA_W-1:0]   item_value,
  output logic                                done,
  output ile_pkg::status_t                    status,
  output logic signed [ile_pkg::DATA_W-1:0]   result_value,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int DW = ile_pkg::DATA_W;

  ile_pkg::state_t state, state_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [CNT_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] cur_dec, cur_inc;
  logic             pend, pend_next;
  logic             pend_first, pend_first_next;
  logic [AW-1:0]    pend_addr, pend_addr_next;
  logic [CNT_W-1:0] op_pos, op_pos_next;
  logic signed [DW-1:0] op_value, op_value_next;
  logic signed [DW-1:0] best, best_next;
  logic             done_next;
  ile_pkg::status_t status_next;
  logic signed [DW-1:0] result_value_next;
  logic [CNT_W-1:0] entry_count_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic signed [DW-1:0] ram_rdata;
  logic             full;

  ile_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_dec = cur - CNT_W'(1);
  assign cur_inc = cur + CNT_W'(1);
  assign full = (fill_count == CNT_W'(CAPACITY));
  assign busy = (state != ile_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ile_pkg::S_IDLE;
      fill_count <= '0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      fill_count <= fill_count_next;
      pend <= pend_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    pend_first <= pend_first_next;
    pend_addr <= pend_addr_next;
    op_pos <= op_pos_next;
    op_value <= op_value_next;
    best <= best_next;
    status <= status_next;
    result_value <= result_value_next;
    entry_count <= entry_count_next;
  end

  always_comb begin
    state_next = state;
    fill_count_next = fill_count;
    cur_next = cur;
    pend_next = 1'b0;
    pend_first_next = pend_first;
    pend_addr_next = pend_addr;
    op_pos_next = op_pos;
    op_value_next = op_value;
    best_next = best;
    done_next = 1'b0;
    status_next = status;
    result_value_next = result_value;
    entry_count_next = entry_count;
    ram_we = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_raddr = cur[AW-1:0];

    case (state)
      ile_pkg::S_IDLE: begin
        if (start) begin
          op_pos_next = position;
          op_value_next = item_value;
          done_next = 1'b1;
          status_next = ile_pkg::ST_OK;
          result_value_next = '0;
          entry_count_next = fill_count;
          case (action)
            ile_pkg::ACT_APPEND: begin
              if (full) begin
                status_next = ile_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                ram_waddr = fill_count[AW-1:0];
                ram_wdata = item_value;
                fill_count_next = fill_count + CNT_W'(1);
                entry_count_next = fill_count + CNT_W'(1);
              end
            end
            ile_pkg::ACT_INSERT: begin
              if (position > fill_count) begin
                status_next = ile_pkg::ST_POS;
              end else if (full) begin
                status_next = ile_pkg::ST_FULL;
              end else begin
                done_next = 1'b0;
                cur_next = fill_count;
                state_next = ile_pkg::S_INSERT;
              end
            end
            ile_pkg::ACT_DELETE: begin
              if (fill_count == '0) begin
                status_next = ile_pkg::ST_EMPTY;
              end else if (position >= fill_count) begin
                status_next = ile_pkg::ST_POS;
              end else begin
                done_next = 1'b0;
                cur_next = position;
                state_next = ile_pkg::S_DELETE;
              end
            end
            default: begin
              if (fill_count == '0) begin
                status_next = ile_pkg::ST_EMPTY;
              end else begin
                done_next = 1'b0;
                cur_next = '0;
                state_next = ile_pkg::S_MIN;
              end
            end
          endcase
        end
      end

      ile_pkg::S_INSERT: begin
        if (pend) begin
          ram_we = 1'b1;
        end
        if (cur > op_pos) begin
          ram_raddr = cur_dec[AW-1:0];
          pend_next = 1'b1;
          pend_addr_next = cur[AW-1:0];
          cur_next = cur_dec;
        end else if (!pend) begin
          ram_we = 1'b1;
          ram_waddr = op_pos[AW-1:0];
          ram_wdata = op_value;
          fill_count_next = fill_count + CNT_W'(1);
          done_next = 1'b1;
          status_next = ile_pkg::ST_OK;
          result_value_next = '0;
          entry_count_next = fill_count + CNT_W'(1);
          state_next = ile_pkg::S_IDLE;
        end
      end

      ile_pkg::S_DELETE: begin
        if (pend) begin
          if (pend_first) begin
            best_next = ram_rdata;
          end else begin
            ram_we = 1'b1;
          end
        end
        if (cur < fill_count) begin
          pend_next = 1'b1;
          pend_first_next = (cur == op_pos);
          pend_addr_next = cur_dec[AW-1:0];
          cur_next = cur_inc;
        end else if (!pend) begin
          fill_count_next = fill_count - CNT_W'(1);
          done_next = 1'b1;
          status_next = ile_pkg::ST_OK;
          result_value_next = best;
          entry_count_next = fill_count - CNT_W'(1);
          state_next = ile_pkg::S_IDLE;
        end
      end

      ile_pkg::S_MIN: begin
        if (pend) begin
          if (pend_first || (ram_rdata < best)) begin
            best_next = ram_rdata;
          end
        end
        if (cur < fill_count) begin
          pend_next = 1'b1;
          pend_first_next = (cur == '0);
          cur_next = cur_inc;
        end else if (!pend) begin
          done_next = 1'b1;
          status_next = ile_pkg::ST_OK;
          result_value_next = best;
          entry_count_next = fill_count;
          state_next = ile_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ile_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ile_checker.sv
// Port-level assertions for the indexed list engine and their bind to the top level.
// Depends on ile_pkg and indexed_list_engine_core.
`timescale 1ns / 1ps

module ile_checker #(
  parameter int CAPACITY = ile_pkg::DEFAULT_CAPACITY
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input ile_pkg::status_t                  status,
  input logic signed [ile_pkg::DATA_W-1:0] result_value,
  input logic [$clog2(CAPACITY+1)-1:0]     entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // A result is only shown once the engine is free for the next transfer.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // Every end of a busy period delivers a result.
  a_fell_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy ended without a result");

  // An accepted transfer either starts a walk or answers on the next cycle.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither busy nor answered");

  // Rejected requests return a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ile_pkg::ST_OK) |-> (result_value == '0))
    else $error("error result carries a nonzero value");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

endmodule

bind indexed_list_engine_core ile_checker #(
  .CAPACITY (CAPACITY)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .result_value (result_value),
  .entry_count  (entry_count)
);

>>> tb/tb_indexed_list_engine_core.sv
// Self-checking testbench for indexed_list_engine_core: a queue-fed driver, a monitor and a
// behavioral list predictor that checks every status, returned value and count.
// Depends on ile_pkg and the indexed list engine RTL.
`timescale 1ns / 1ps

module tb_indexed_list_engine_core;
  import ile_pkg::*;

  localparam int CAP = 64;
  localparam int PW = $clog2(CAP + 1);
  localparam int POS_MAX = (1 << PW) - 1;
  localparam int RANDOM_ITEMS = 1530;
  localparam int DRAIN_CYCLES = 2 * CAP + 20;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    action_t            act;
    logic [PW-1:0]      pos;
    logic signed [31:0] val;
    int                 idle_pct;
  } list_request_t;

  typedef struct {
    status_t            st;
    logic signed [31:0] val;
    logic [PW-1:0]      count;
  } list_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  action_t            action = ACT_APPEND;
  logic [PW-1:0]      position = '0;
  logic signed [31:0] item_value = '0;
  logic               done;
  status_t            status;
  logic signed [31:0] result_value;
  logic [PW-1:0]      entry_count;

  list_request_t      requests_pending[$];
  list_reply_t        replies_due[$];

  logic signed [31:0] list_vals[CAP];
  int                 list_len = 0;
  int                 plan_len = 0;

  int                 cycle_count = 0;
  int                 bad_count = 0;
  int                 checked_count = 0;
  int                 peak_fill = 0;
  int                 action_seen[4] = '{default: 0};
  int                 status_seen[4] = '{default: 0};

  indexed_list_engine_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .position(position),
    .item_value(item_value),
    .done(done),
    .status(status),
    .result_value(result_value),
    .entry_count(entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic list_reply_t apply_list_op(input list_request_t req);
    list_reply_t rep;
    logic signed [31:0] best;
    rep.st = ST_OK;
    rep.val = '0;
    case (req.act)
      ACT_APPEND: begin
        if (list_len >= CAP) begin
          rep.st = ST_FULL;
        end else begin
          list_vals[list_len] = req.val;
          list_len++;
        end
      end
      ACT_INSERT: begin
        if (int'(req.pos) > list_len) begin
          rep.st = ST_POS;
        end else if (list_len >= CAP) begin
          rep.st = ST_FULL;
        end else begin
          for (int i = list_len; i > int'(req.pos); i--) list_vals[i] = list_vals[i-1];
          list_vals[req.pos] = req.val;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (list_len == 0) begin
          rep.st = ST_EMPTY;
        end else if (int'(req.pos) >= list_len) begin
          rep.st = ST_POS;
        end else begin
          rep.val = list_vals[req.pos];
          for (int i = int'(req.pos); i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: begin
        if (list_len == 0) begin
          rep.st = ST_EMPTY;
        end else begin
          best = list_vals[0];
          for (int i = 1; i < list_len; i++) if (list_vals[i] < best) best = list_vals[i];
          rep.val = best;
        end
      end
    endcase
    rep.count = list_len[PW-1:0];
    return rep;
  endfunction

  // The planner tracks only the list length so that positions can be aimed at valid slots.
  task automatic plan_request(input action_t a, input int p, input logic [31:0] v,
                              input int idle);
    list_request_t req;
    req.act = a;
    req.pos = p[PW-1:0];
    req.val = v;
    req.idle_pct = idle;
    requests_pending.push_back(req);
    case (a)
      ACT_APPEND: if (plan_len < CAP) plan_len++;
      ACT_INSERT: if (p <= plan_len && plan_len < CAP) plan_len++;
      ACT_DELETE: if (plan_len > 0 && p < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32'h8000_0000;
    if (r < 8) return 32'h7FFF_FFFF;
    if (r < 10) return 32'hFFFF_FFFF;
    if (r < 12) return 32'h0;
    if (r < 32) return 32'($signed($urandom_range(16)) - 8);
    return $urandom;
  endfunction

  always @(posedge clk) begin : driver
    logic taken;
    taken = !rst && start && !busy;
    if (taken) begin
      action_seen[requests_pending[0].act]++;
      replies_due.push_back(apply_list_op(requests_pending.pop_front()));
    end
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (requests_pending.size() != 0 &&
          $urandom_range(99) >= requests_pending[0].idle_pct) begin
        start <= 1'b1;
        action <= requests_pending[0].act;
        position <= requests_pending[0].pos;
        item_value <= requests_pending[0].val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    list_reply_t want;
    if (!rst && done) begin
      status_seen[status]++;
      if (int'(entry_count) > peak_fill) peak_fill = int'(entry_count);
      if (replies_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected result status=%0d value=%0d count=%0d",
                   $realtime, status, result_value, entry_count);
      end else begin
        want = replies_due.pop_front();
        checked_count++;
        if (status !== want.st || result_value !== want.val || entry_count !== want.count) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: result %0d expected status=%0d value=%0d count=%0d, got status=%0d value=%0d count=%0d",
                     $realtime, checked_count, want.st, want.val, want.count,
                     status, result_value, entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d requests and %0d results outstanding.",
               cycle_count, requests_pending.size(), replies_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_idle[3];
    int idle;
    int r;
    int p;
    bit growing;
    action_t a;
    phase_idle = '{0, 62, 13};
    growing = 1'b1;

    plan_request(ACT_MIN, 0, 32'h0, 0);
    plan_request(ACT_DELETE, 0, 32'h0, 0);
    plan_request(ACT_DELETE, POS_MAX, 32'h0, 0);
    plan_request(ACT_INSERT, 1, 32'h1234_5678, 0);
    plan_request(ACT_INSERT, 0, 32'h7FFF_FFFF, 0);
    plan_request(ACT_APPEND, 0, 32'h8000_0000, 0);
    plan_request(ACT_APPEND, 0, 32'hFFFF_FFFF, 0);
    plan_request(ACT_APPEND, 0, 32'h0, 0);
    plan_request(ACT_INSERT, 0, 32'h5, 0);
    plan_request(ACT_INSERT, 5, 32'h5555_5555, 0);
    plan_request(ACT_INSERT, 2, 32'hAAAA_AAAA, 0);
    plan_request(ACT_INSERT, POS_MAX, 32'h1, 0);
    plan_request(ACT_MIN, 0, 32'h0, 0);
    plan_request(ACT_DELETE, 7, 32'h0, 0);
    plan_request(ACT_DELETE, POS_MAX, 32'h0, 0);
    plan_request(ACT_DELETE, 6, 32'h0, 0);
    plan_request(ACT_DELETE, 0, 32'h0, 0);
    plan_request(ACT_DELETE, 2, 32'h0, 0);
    plan_request(ACT_MIN, 0, 32'h0, 0);
    plan_request(ACT_APPEND, 0, 32'h1, 0);

    // Alternate long growing and shrinking runs so the list hits both full and empty often.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      idle = phase_idle[k * 3 / RANDOM_ITEMS];
      if (growing && plan_len == CAP && $urandom_range(99) < 25) growing = 1'b0;
      if (!growing && plan_len == 0 && $urandom_range(99) < 25) growing = 1'b1;
      r = $urandom_range(99);
      if (r >= 90) begin
        a = action_t'($urandom_range(3));
        p = $urandom_range(POS_MAX);
      end else if (growing ? (r < 40) : (r < 8)) begin
        a = ACT_APPEND;
        p = $urandom_range(POS_MAX);
      end else if (growing ? (r < 72) : (r < 18)) begin
        a = ACT_INSERT;
        r = $urandom_range(9);
        p = (r == 0) ? 0 : (r == 1) ? plan_len : $urandom_range(plan_len);
      end else if (growing ? (r < 82) : (r < 75)) begin
        a = ACT_DELETE;
        r = $urandom_range(9);
        if (plan_len == 0) p = $urandom_range(POS_MAX);
        else p = (r == 0) ? 0 : (r == 1) ? plan_len - 1 : $urandom_range(plan_len - 1);
      end else begin
        a = ACT_MIN;
        p = $urandom_range(POS_MAX);
      end
      plan_request(a, p, pick_value(), idle);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (requests_pending.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d appends, %0d inserts, %0d deletes and %0d minimum scans; %0d results checked.",
             action_seen[ACT_APPEND], action_seen[ACT_INSERT], action_seen[ACT_DELETE],
             action_seen[ACT_MIN], checked_count);
    $display("Outcomes: %0d ok, %0d bad position, %0d empty list, %0d full list; peak fill %0d of %0d.",
             status_seen[ST_OK], status_seen[ST_POS], status_seen[ST_EMPTY],
             status_seen[ST_FULL], peak_fill, CAP);
    if (bad_count == 0 && replies_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", bad_count, replies_due.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
